// ===== hw/rtl/ctc_pkg.sv =====
// shared types and constants of the columnar transposition cipher
package ctc_pkg;

	localparam int KEY_BITS     = 64;
	localparam int KEY_LEN_BITS = 4;
	localparam int CHAR_BITS    = 8;

	localparam logic [CHAR_BITS-1:0] PAD_CHAR   = 8'h5F;
	localparam logic [CHAR_BITS-1:0] SPACE_CHAR = 8'h20;

	localparam logic MODE_ENC = 1'b0;

	localparam logic CFG_KEY_CHARS  = 1'b0;
	localparam logic CFG_KEY_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ORDER,
		ST_CAP,
		ST_DIV,
		ST_TOTAL,
		ST_READ,
		ST_DATA
	} ctc_state_t;

endpackage

// ===== hw/rtl/ctc_ram.sv =====
// generic single write port ram with registered read
module ctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/ctc_order.sv =====
// key ranking: one shared comparator walks all column pairs
module ctc_order #(
	parameter int MAX_KEY_LENGTH = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [ctc_pkg::KEY_BITS-1:0]               key,
	input  logic [$clog2(MAX_KEY_LENGTH+1)-1:0]        k,
	output logic                                       done,
	output logic [MAX_KEY_LENGTH*$clog2(MAX_KEY_LENGTH)-1:0] perm,
	output logic [MAX_KEY_LENGTH*$clog2(MAX_KEY_LENGTH)-1:0] rank
);

	localparam int IW = $clog2(MAX_KEY_LENGTH);
	localparam int KW = $clog2(MAX_KEY_LENGTH+1);

	logic          busy_q;
	logic          done_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] cnt_q;
	logic [MAX_KEY_LENGTH*IW-1:0] perm_q;
	logic [MAX_KEY_LENGTH*IW-1:0] rank_q;

	logic [ctc_pkg::CHAR_BITS-1:0] ci;
	logic [ctc_pkg::CHAR_BITS-1:0] cj;
	logic                          lt;
	logic [IW-1:0]                 cnt_nxt;
	logic                          j_end;
	logic                          i_end;

	// column j goes ahead of column i: smaller char, or equal char at lower index
	assign ci      = key[ctc_pkg::CHAR_BITS*i_q +: ctc_pkg::CHAR_BITS];
	assign cj      = key[ctc_pkg::CHAR_BITS*j_q +: ctc_pkg::CHAR_BITS];
	assign lt      = (cj < ci) || ((cj == ci) && (j_q < i_q));
	assign cnt_nxt = cnt_q + IW'(lt);
	assign j_end   = (KW'(j_q) == k - KW'(1));
	assign i_end   = (KW'(i_q) == k - KW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (j_end) begin
					j_q   <= '0;
					cnt_q <= '0;
					if (i_end) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end else begin
					j_q   <= j_q + IW'(1);
					cnt_q <= cnt_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start && j_end) begin
			perm_q[IW*cnt_nxt +: IW] <= i_q;
			rank_q[IW*i_q +: IW]     <= cnt_nxt;
		end
	end

	assign done = done_q;
	assign perm = perm_q;
	assign rank = rank_q;

endmodule

// ===== hw/rtl/columnar_transposition_cipher.sv =====
// columnar transposition cipher: byte collector, ranking, shared multiply-add sequencer
//
//  channel   dir  width  contents (lowest bit first)      transfer when
//  s_*       in   8+1+1  tdata data_byte, tuser mode,     s_tvalid & s_tready
//                        tlast last_byte
//  m_*       out  8+1+1  tdata out_byte, tuser overflow,  m_tvalid & m_tready
//                        tlast out_last
//  cfg_*     in   1+64   index, data (key_chars, key_len) cfg_we
//
//  bytes load at one per cycle; after the last byte the block is not ready while it
//  ranks the key, finds the buffer cap, counts rows, works out the burst length, then
//  sends each result byte through a ram read and the output register
//  the ram read and the shared multiply-add serve one result byte at a time
//  reset clears control state and key chars, key length to one; text ram not cleared
//  an output stall holds the burst in the data state; input stays blocked meanwhile
module columnar_transposition_cipher #(
	parameter int BUFFER_DEPTH   = 64,
	parameter int MAX_KEY_LENGTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tuser,   // mode
	input  logic                            s_tlast,   // last_byte
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // out_byte
	output logic                            m_tuser,   // overflow
	output logic                            m_tlast,   // out_last
	// configuration writes
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [ctc_pkg::KEY_BITS-1:0]    cfg_data
);

	localparam int CW = $clog2(BUFFER_DEPTH+1);   // counts up to the depth itself
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int IW = $clog2(MAX_KEY_LENGTH);
	localparam int KW = $clog2(MAX_KEY_LENGTH+1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
	localparam logic [CW:0]   DEPTH_W = (CW+1)'(BUFFER_DEPTH);

	ctc_pkg::ctc_state_t state_q, state_nxt;

	// configuration
	logic [ctc_pkg::KEY_BITS-1:0]     key_q;
	logic [ctc_pkg::KEY_LEN_BITS-1:0] key_len_q;
	logic [KW-1:0]                    k_eff;

	// message state
	logic [CW-1:0] cnt_q;      // bytes held
	logic          mode_q;
	logic          ovf_q;
	logic [CW-1:0] n_q;        // bytes used after truncation
	logic [CW-1:0] acc_q;      // running multiple of k
	logic [CW-1:0] q_q;        // row count
	logic [CW-1:0] total_q;    // burst length
	logic [CW-1:0] a_q;        // outer walk: rank (encrypt) or row (decrypt)
	logic [CW-1:0] b_q;        // inner walk: row (encrypt) or column (decrypt)
	logic [CW-1:0] e_q;        // results issued

	// read pipeline and output register
	logic                          pad_s1;
	logic                          last_s1;
	logic                          out_v_q;
	logic [ctc_pkg::CHAR_BITS-1:0] out_byte_q;
	logic                          out_last_q;
	logic                          out_ovf_q;

	logic                                s_acc;
	logic                                enc;
	logic                                ram_we;
	logic                                ram_re;
	logic [ctc_pkg::CHAR_BITS-1:0]       ram_rdata;
	logic                                ord_start;
	logic                                ord_done;
	logic [MAX_KEY_LENGTH*IW-1:0]        perm;
	logic [MAX_KEY_LENGTH*IW-1:0]        rank;
	logic [IW-1:0]                       perm_sel;
	logic [IW-1:0]                       rank_sel;
	logic [CW:0]                         sum_acc;
	logic                                cap_fit;
	logic                                div_fit;
	logic [CW-1:0]                       capm;
	logic [CW-1:0]                       mul_x;
	logic [CW-1:0]                       mul_y;
	logic [CW-1:0]                       mul_add;
	logic [2*CW-1:0]                     prod;
	logic [CW-1:0]                       mac;
	logic [CW-1:0]                       inner_lim;
	logic                                b_end;
	logic                                data_go;
	logic [ctc_pkg::CHAR_BITS-1:0]       res_byte;

	// key length out of range folds to the nearest legal column count
	always_comb begin
		if (key_len_q == '0) begin
			k_eff = KW'(1);
		end else if (key_len_q > ctc_pkg::KEY_LEN_BITS'(MAX_KEY_LENGTH)) begin
			k_eff = KW'(MAX_KEY_LENGTH);
		end else begin
			k_eff = KW'(key_len_q);
		end
	end

	assign s_acc = s_tvalid && s_tready;
	assign enc   = (mode_q == ctc_pkg::MODE_ENC);

	// cap and row count both step the same adder by k
	assign sum_acc = {1'b0, acc_q} + (CW+1)'(k_eff);
	assign cap_fit = (sum_acc <= DEPTH_W);
	assign div_fit = (sum_acc <= {1'b0, n_q});
	// encrypt keeps one slot for the padding row
	assign capm    = enc ? (acc_q - CW'(1)) : acc_q;

	assign perm_sel = perm[IW*a_q[IW-1:0] +: IW];
	assign rank_sel = rank[IW*b_q[IW-1:0] +: IW];

	// shared multiply-add: burst length, then one address per result
	always_comb begin
		case (state_q)
			ctc_pkg::ST_TOTAL: begin
				mul_x   = q_q;
				mul_y   = CW'(k_eff);
				mul_add = '0;
			end
			default: begin
				if (enc) begin
					mul_x   = b_q;
					mul_y   = CW'(k_eff);
					mul_add = CW'(perm_sel);
				end else begin
					mul_x   = CW'(rank_sel);
					mul_y   = q_q;
					mul_add = a_q;
				end
			end
		endcase
	end

	assign prod = mul_x * mul_y;
	assign mac  = prod[CW-1:0] + mul_add;

	assign inner_lim = enc ? q_q : CW'(k_eff);
	assign b_end     = (b_q == inner_lim - CW'(1));
	assign data_go   = !out_v_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ctc_pkg::ST_LOAD: begin
				if (s_acc && s_tlast) state_nxt = ctc_pkg::ST_ORDER;
			end
			ctc_pkg::ST_ORDER: begin
				if (ord_done) state_nxt = ctc_pkg::ST_CAP;
			end
			ctc_pkg::ST_CAP: begin
				if (!cap_fit) state_nxt = ctc_pkg::ST_DIV;
			end
			ctc_pkg::ST_DIV: begin
				if (!div_fit) state_nxt = ctc_pkg::ST_TOTAL;
			end
			ctc_pkg::ST_TOTAL: begin
				state_nxt = ctc_pkg::ST_READ;
			end
			ctc_pkg::ST_READ: begin
				state_nxt = ctc_pkg::ST_DATA;
			end
			ctc_pkg::ST_DATA: begin
				if (data_go) state_nxt = last_s1 ? ctc_pkg::ST_LOAD : ctc_pkg::ST_READ;
			end
			default: begin
				state_nxt = ctc_pkg::ST_LOAD;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ord_start = 1'b0;
		case (state_q)
			ctc_pkg::ST_LOAD: begin
				s_tready  = 1'b1;
				ord_start = s_tvalid && s_tlast;
			end
			ctc_pkg::ST_READ: begin
				ram_re = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// bytes past the buffer are dropped and flag the message
	assign ram_we = s_acc && (cnt_q < DEPTH_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ctc_pkg::ST_LOAD;
			key_q     <= '0;
			key_len_q <= ctc_pkg::KEY_LEN_BITS'(1);
			cnt_q     <= '0;
			mode_q    <= 1'b0;
			ovf_q     <= 1'b0;
			n_q       <= '0;
			acc_q     <= '0;
			q_q       <= '0;
			total_q   <= '0;
			a_q       <= '0;
			b_q       <= '0;
			e_q       <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_we) begin
				case (cfg_index)
					ctc_pkg::CFG_KEY_CHARS:  key_q     <= cfg_data;
					ctc_pkg::CFG_KEY_LENGTH: key_len_q <= cfg_data[ctc_pkg::KEY_LEN_BITS-1:0];
					default:                 key_q     <= key_q;
				endcase
			end

			case (state_q)
				ctc_pkg::ST_LOAD: begin
					if (s_acc) begin
						if (cnt_q == '0) mode_q <= s_tuser;
						if (cnt_q < DEPTH_C) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					acc_q <= '0;
				end
				ctc_pkg::ST_CAP: begin
					if (cap_fit) begin
						acc_q <= sum_acc[CW-1:0];
					end else begin
						// truncate so the burst fits the buffer
						if (cnt_q > capm) begin
							n_q   <= capm;
							ovf_q <= 1'b1;
						end else begin
							n_q <= cnt_q;
						end
						acc_q <= '0;
						q_q   <= '0;
					end
				end
				ctc_pkg::ST_DIV: begin
					if (div_fit) begin
						acc_q <= sum_acc[CW-1:0];
						q_q   <= q_q + CW'(1);
					end else if (enc) begin
						// encrypt always adds a padding row
						q_q <= q_q + CW'(1);
					end else if (acc_q != n_q) begin
						// ragged ciphertext rounds up
						q_q <= q_q + CW'(1);
					end
				end
				ctc_pkg::ST_TOTAL: begin
					total_q <= mac;
					a_q     <= '0;
					b_q     <= '0;
					e_q     <= '0;
				end
				ctc_pkg::ST_READ: begin
					e_q <= e_q + CW'(1);
					if (b_end) begin
						b_q <= '0;
						a_q <= a_q + CW'(1);
					end else begin
						b_q <= b_q + CW'(1);
					end
				end
				ctc_pkg::ST_DATA: begin
					if (data_go && last_s1) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase

			if ((state_q == ctc_pkg::ST_DATA) && data_go) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// cells past the used bytes are padding
	always_ff @(posedge clk) begin
		if (state_q == ctc_pkg::ST_READ) begin
			pad_s1  <= (mac >= n_q);
			last_s1 <= (e_q == total_q - CW'(1));
		end
	end

	// decrypt shows padding as spaces
	always_comb begin
		if (pad_s1) begin
			res_byte = enc ? ctc_pkg::PAD_CHAR : ctc_pkg::SPACE_CHAR;
		end else if (!enc && (ram_rdata == ctc_pkg::PAD_CHAR)) begin
			res_byte = ctc_pkg::SPACE_CHAR;
		end else begin
			res_byte = ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ctc_pkg::ST_DATA) && data_go) begin
			out_byte_q <= res_byte;
			out_last_q <= last_s1;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	ctc_ram #(
		.WIDTH(ctc_pkg::CHAR_BITS),
		.DEPTH(BUFFER_DEPTH)
	) u_text (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(mac[AW-1:0]),
		.rdata(ram_rdata)
	);

	ctc_order #(
		.MAX_KEY_LENGTH(MAX_KEY_LENGTH)
	) u_order (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ord_start),
		.key   (key_q),
		.k     (k_eff),
		.done  (ord_done),
		.perm  (perm),
		.rank  (rank)
	);

endmodule
